// ===== rtl/assert_macros.svh =====
// assertion macros used by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ===== rtl/bsc_pkg.sv =====
// shared constants, types and width helpers of the safety check unit
package bsc_pkg;

	localparam int BSC_MAX_PROCS = 8;
	localparam int BSC_MAX_RES   = 4;
	localparam int BSC_UNIT_BITS = 8;

	localparam int AVAIL_W    = 11;
	localparam int TOTAL_W    = 8;
	localparam int NUM_TOTALS = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PROCS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RES    = 3'd5;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET [NUM_TOTALS] = '{8'd10, 8'd5, 8'd7, 8'd0};
	localparam logic [3:0] PROCS_RESET = 4'd5;
	localparam logic [2:0] RES_RESET   = 3'd3;

	// input item functions
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ORDER     = 2'd0;
	localparam logic [1:0] KIND_SAFE      = 2'd1;
	localparam logic [1:0] KIND_DEADLOCK  = 2'd2;
	localparam logic [1:0] KIND_OVERALLOC = 2'd3;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_FIT = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic borrow;
		logic fits;
	} alu_flags_t;

	// bits to index an array of the given depth
	function automatic int idx_bits(int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// bits of a counter that must also hold the depth itself
	function automatic int cnt_bits(int depth);
		return $clog2(depth + 1);
	endfunction

	// datapath width of the shared unit
	function automatic int alu_width(int max_procs, int unit_bits);
		int w;
		w = unit_bits + cnt_bits(max_procs);
		if (AVAIL_W > w) w = AVAIL_W;
		if (TOTAL_W > w) w = TOTAL_W;
		return w;
	endfunction

endpackage

// ===== rtl/bsc_table_mem.sv =====
// allocation and maximum tables, one write port and one registered read port
module bsc_table_mem
	import bsc_pkg::*;
#(
	parameter int MAX_PROCS = BSC_MAX_PROCS,
	parameter int MAX_RES   = BSC_MAX_RES,
	parameter int UNIT_BITS = BSC_UNIT_BITS,
	localparam int ADDR_W   = idx_bits(MAX_PROCS) + idx_bits(MAX_RES)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [UNIT_BITS-1:0] wr_alloc,
	input  logic [UNIT_BITS-1:0] wr_max,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output logic [UNIT_BITS-1:0] rd_alloc,
	output logic [UNIT_BITS-1:0] rd_max
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [UNIT_BITS-1:0] alloc_mem [DEPTH];
	logic [UNIT_BITS-1:0] max_mem   [DEPTH];
	logic [UNIT_BITS-1:0] alloc_rd_q;
	logic [UNIT_BITS-1:0] max_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			alloc_mem[wr_addr] <= wr_alloc;
			max_mem[wr_addr]   <= wr_max;
		end
		if (rd_en) begin
			alloc_rd_q <= alloc_mem[rd_addr];
			max_rd_q   <= max_mem[rd_addr];
		end
	end

	assign rd_alloc = alloc_rd_q;
	assign rd_max   = max_rd_q;

endmodule

// ===== rtl/bsc_alu.sv =====
// shared adder/subtractor with saturating need compare
module bsc_alu
	import bsc_pkg::*;
#(
	parameter int ALU_W = alu_width(BSC_MAX_PROCS, BSC_UNIT_BITS)
) (
	input  alu_op_t          op,
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	input  logic [ALU_W-1:0] c,
	output logic [ALU_W-1:0] res,
	output alu_flags_t       flags
);

	logic             sub;
	logic [ALU_W:0]   sum_w;
	logic [ALU_W-1:0] need;

	always_comb begin
		sub          = (op != ALU_ADD);
		sum_w        = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (ALU_W+1)'(sub);
		res          = sum_w[ALU_W-1:0];
		flags.borrow = sub & ~sum_w[ALU_W];
		// need saturates at zero when maximum is below allocation
		need         = flags.borrow ? '0 : sum_w[ALU_W-1:0];
		flags.fits   = (op == ALU_FIT) && (need <= c);
	end

endmodule

// ===== rtl/bsc_seq.sv =====
// sequencer: column sums, safety scan passes and result register
`include "assert_macros.svh"

module bsc_seq
	import bsc_pkg::*;
#(
	parameter int MAX_PROCS = BSC_MAX_PROCS,
	parameter int MAX_RES   = BSC_MAX_RES,
	parameter int UNIT_BITS = BSC_UNIT_BITS,
	localparam int PW       = idx_bits(MAX_PROCS),
	localparam int RW       = idx_bits(MAX_RES),
	localparam int NW       = cnt_bits(MAX_PROCS),
	localparam int MW       = cnt_bits(MAX_RES),
	localparam int ALU_W    = alu_width(MAX_PROCS, UNIT_BITS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 idle,
	input  logic [NW-1:0]        n_procs,
	input  logic [MW-1:0]        n_res,
	input  logic [TOTAL_W-1:0]   totals [NUM_TOTALS],
	output logic                 rd_en,
	output logic [PW+RW-1:0]     rd_addr,
	input  logic [UNIT_BITS-1:0] rd_alloc,
	input  logic [UNIT_BITS-1:0] rd_max,
	output alu_op_t              alu_op,
	output logic [ALU_W-1:0]     alu_a,
	output logic [ALU_W-1:0]     alu_b,
	output logic [ALU_W-1:0]     alu_c,
	input  logic [ALU_W-1:0]     alu_res,
	input  alu_flags_t           alu_flags,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           entry_kind,
	output logic [2:0]           process_out,
	output logic                 last
);

	localparam int SUM_W = UNIT_BITS + NW;

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_SUM_RD  = 10'b0000000010,
		ST_SUM_ACC = 10'b0000000100,
		ST_SUM_CHK = 10'b0000001000,
		ST_SCAN    = 10'b0000010000,
		ST_FIT_RD  = 10'b0000100000,
		ST_FIT_CHK = 10'b0001000000,
		ST_ADD_RD  = 10'b0010000000,
		ST_ADD_ACC = 10'b0100000000,
		ST_EMIT    = 10'b1000000000
	} state_t;

	state_t               state_q;
	logic [NW-1:0]        p_q;
	logic [MW-1:0]        r_q;
	logic [SUM_W-1:0]     sum_q;
	logic [AVAIL_W-1:0]   avail_q [MAX_RES];
	logic [MAX_PROCS-1:0] finished_q;
	logic [NW-1:0]        order_cnt_q;
	logic                 progress_q;
	logic [1:0]           emit_kind_q;
	logic [2:0]           emit_proc_q;
	logic                 emit_last_q;
	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [2:0]           out_proc_q;
	logic                 out_last_q;

	logic [PW-1:0]        p_idx;
	logic [RW-1:0]        r_idx;
	logic [TOTAL_W-1:0]   tot_ext [MAX_RES];

	assign p_idx = p_q[PW-1:0];
	assign r_idx = r_q[RW-1:0];

	// resources beyond the total registers own nothing
	for (genvar k = 0; k < MAX_RES; k++) begin : g_tot
		if (k < NUM_TOTALS) begin : g_reg
			assign tot_ext[k] = totals[k];
		end else begin : g_zero
			assign tot_ext[k] = '0;
		end
	end

	assign idle    = (state_q == ST_IDLE);
	assign rd_addr = {p_idx, r_idx};
	assign rd_en   = ((state_q == ST_SUM_RD) && (p_q != n_procs)) ||
	                 (state_q == ST_FIT_RD) ||
	                 ((state_q == ST_ADD_RD) && (r_q != n_res));

	// operand steering for the shared unit
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		alu_c  = '0;
		unique case (state_q)
			ST_SUM_ACC: begin
				alu_op = ALU_ADD;
				alu_a  = ALU_W'(sum_q);
				alu_b  = ALU_W'(rd_alloc);
			end
			ST_SUM_CHK: begin
				alu_op = ALU_SUB;
				alu_a  = ALU_W'(tot_ext[r_idx]);
				alu_b  = ALU_W'(sum_q);
			end
			ST_FIT_CHK: begin
				alu_op = ALU_FIT;
				alu_a  = ALU_W'(rd_max);
				alu_b  = ALU_W'(rd_alloc);
				alu_c  = ALU_W'(avail_q[r_idx]);
			end
			ST_ADD_ACC: begin
				alu_op = ALU_ADD;
				alu_a  = ALU_W'(avail_q[r_idx]);
				alu_b  = ALU_W'(rd_alloc);
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			p_q         <= '0;
			r_q         <= '0;
			sum_q       <= '0;
			for (int k = 0; k < MAX_RES; k++) avail_q[k] <= '0;
			finished_q  <= '0;
			order_cnt_q <= '0;
			progress_q  <= 1'b0;
			emit_kind_q <= KIND_ORDER;
			emit_proc_q <= '0;
			emit_last_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_ORDER;
			out_proc_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// the emit state refills the register itself when it drains
			if (out_valid_q && out_ready && (state_q != ST_EMIT)) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						finished_q  <= '0;
						order_cnt_q <= '0;
						progress_q  <= 1'b0;
						p_q         <= '0;
						r_q         <= '0;
						sum_q       <= '0;
						state_q     <= (n_res == '0) ? ST_SCAN : ST_SUM_RD;
					end
				end
				ST_SUM_RD: begin
					state_q <= (p_q == n_procs) ? ST_SUM_CHK : ST_SUM_ACC;
				end
				ST_SUM_ACC: begin
					sum_q   <= alu_res[SUM_W-1:0];
					p_q     <= p_q + NW'(1);
					state_q <= ST_SUM_RD;
				end
				ST_SUM_CHK: begin
					if (alu_flags.borrow) begin
						emit_kind_q <= KIND_OVERALLOC;
						emit_proc_q <= '0;
						emit_last_q <= 1'b1;
						state_q     <= ST_EMIT;
					end else begin
						avail_q[r_idx] <= alu_res[AVAIL_W-1:0];
						sum_q          <= '0;
						p_q            <= '0;
						r_q            <= r_q + MW'(1);
						state_q        <= (r_q + MW'(1) == n_res) ? ST_SCAN : ST_SUM_RD;
					end
				end
				ST_SCAN: begin
					if (p_q == n_procs) begin
						// end of a pass, or no processes at all
						if (order_cnt_q == n_procs) begin
							emit_kind_q <= KIND_SAFE;
							emit_proc_q <= '0;
							emit_last_q <= 1'b1;
							state_q     <= ST_EMIT;
						end else if (!progress_q) begin
							emit_kind_q <= KIND_DEADLOCK;
							emit_proc_q <= '0;
							emit_last_q <= 1'b1;
							state_q     <= ST_EMIT;
						end else begin
							p_q        <= '0;
							progress_q <= 1'b0;
						end
					end else if (finished_q[p_idx]) begin
						p_q <= p_q + NW'(1);
					end else begin
						r_q     <= '0;
						state_q <= (n_res == '0) ? ST_ADD_RD : ST_FIT_RD;
					end
				end
				ST_FIT_RD: begin
					state_q <= ST_FIT_CHK;
				end
				ST_FIT_CHK: begin
					if (!alu_flags.fits) begin
						p_q     <= p_q + NW'(1);
						state_q <= ST_SCAN;
					end else if (r_q + MW'(1) == n_res) begin
						r_q     <= '0;
						state_q <= ST_ADD_RD;
					end else begin
						r_q     <= r_q + MW'(1);
						state_q <= ST_FIT_RD;
					end
				end
				ST_ADD_RD: begin
					if (r_q == n_res) begin
						// allocation returned, grant this process
						finished_q[p_idx] <= 1'b1;
						order_cnt_q       <= order_cnt_q + NW'(1);
						progress_q        <= 1'b1;
						emit_kind_q       <= KIND_ORDER;
						emit_proc_q       <= 3'(p_q);
						emit_last_q       <= 1'b0;
						p_q               <= p_q + NW'(1);
						state_q           <= ST_EMIT;
					end else begin
						state_q <= ST_ADD_ACC;
					end
				end
				ST_ADD_ACC: begin
					avail_q[r_idx] <= alu_res[AVAIL_W-1:0];
					r_q            <= r_q + MW'(1);
					state_q        <= ST_ADD_RD;
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= emit_kind_q;
						out_proc_q  <= emit_proc_q;
						out_last_q  <= emit_last_q;
						state_q     <= emit_last_q ? ST_IDLE : ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_kind  = out_kind_q;
	assign process_out = out_proc_q;
	assign last        = out_last_q;

	`ASSERT_PROP(a_fin_count, clk, arst_n, $countones(finished_q) == int'(order_cnt_q), "finished flags disagree with order count")
	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, (state_q != ST_IDLE) && (order_cnt_q > n_procs), "order count beyond process count")
	`ASSERT_NEVER(a_rd_range, clk, arst_n, rd_en && (p_q >= n_procs), "table read past processes in use")
	`ASSERT_PROP(a_emit_hold, clk, arst_n, (state_q == ST_EMIT) && out_valid_q && !out_ready |=> (state_q == ST_EMIT), "result dropped while output register full")

endmodule

// ===== rtl/banker_safety_check_unit.sv =====
// top level of the banker's algorithm safety check unit
//
//  channel | handshake                 | beat payload
//  --------+---------------------------+---------------------------------------------
//  in      | in_valid / in_ready       | func, process_index, resource_index,
//          |                           | allocated, maximum
//  out     | out_valid / out_ready     | entry_kind, process_out, last
//  cfg     | cfg_we (no back-pressure) | cfg_index, cfg_data
//
//  a load beat writes the tables at once; loads may stream back to back
//  a check beat runs through the single table read port and the shared adder: column
//  sums first, then passes in which a finished process is skipped, an unfinished one
//  is checked resource by resource until one does not fit, and a process that fits
//  returns its allocation and emits its order beat; each pass closes with a verdict
//  or a new pass
//  in_ready stays low from check accept until the last result enters the output
//  register; a full output register stalls the sequencer in place
//  arst_n clears control state and loads the configuration defaults; tables are
//  undefined until written
module banker_safety_check_unit
	import bsc_pkg::*;
#(
	parameter int MAX_PROCS = BSC_MAX_PROCS,
	parameter int MAX_RES   = BSC_MAX_RES,
	parameter int UNIT_BITS = BSC_UNIT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input item channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [2:0]            process_index,
	input  logic [1:0]            resource_index,
	input  logic [7:0]            allocated,
	input  logic [7:0]            maximum,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            entry_kind,
	output logic [2:0]            process_out,
	output logic                  last,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW     = idx_bits(MAX_PROCS);
	localparam int RW     = idx_bits(MAX_RES);
	localparam int ADDR_W = PW + RW;
	localparam int NW     = cnt_bits(MAX_PROCS);
	localparam int MW     = cnt_bits(MAX_RES);
	localparam int ALU_W  = alu_width(MAX_PROCS, UNIT_BITS);

	// configuration registers
	logic [TOTAL_W-1:0] total_q [NUM_TOTALS];
	logic [3:0]         procs_q;
	logic [2:0]         res_q;

	// counts clipped to what the tables hold
	logic [NW-1:0]      n_procs;
	logic [MW-1:0]      n_res;

	// input beat decode
	logic               in_fire;
	logic               load_fire;
	logic               check_start;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;

	// table read path
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [UNIT_BITS-1:0] rd_alloc;
	logic [UNIT_BITS-1:0] rd_max;

	// shared unit
	alu_op_t            alu_op;
	logic [ALU_W-1:0]   alu_a;
	logic [ALU_W-1:0]   alu_b;
	logic [ALU_W-1:0]   alu_c;
	logic [ALU_W-1:0]   alu_res;
	alu_flags_t         alu_flags;

	logic               seq_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TOTALS; k++) total_q[k] <= TOTAL_RESET[k];
			procs_q <= PROCS_RESET;
			res_q   <= RES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL0: total_q[0] <= cfg_data;
				CFG_TOTAL1: total_q[1] <= cfg_data;
				CFG_TOTAL2: total_q[2] <= cfg_data;
				CFG_TOTAL3: total_q[3] <= cfg_data;
				CFG_PROCS:  procs_q    <= cfg_data[3:0];
				CFG_RES:    res_q      <= cfg_data[2:0];
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	// saturate the counts at the table dimensions
	assign n_procs = (int'(procs_q) > MAX_PROCS) ? NW'(MAX_PROCS) : NW'(procs_q);
	assign n_res   = (int'(res_q) > MAX_RES) ? MW'(MAX_RES) : MW'(res_q);

	assign in_ready    = seq_idle;
	assign in_fire     = in_valid && in_ready;
	assign load_fire   = in_fire && (func == FUNC_LOAD);
	assign check_start = in_fire && (func == FUNC_CHECK);

	// loads outside the table dimensions are ignored
	assign wr_en   = load_fire && (int'(process_index) < MAX_PROCS) &&
	                 (int'(resource_index) < MAX_RES);
	assign wr_addr = {PW'(process_index), RW'(resource_index)};

	bsc_table_mem #(
		.MAX_PROCS (MAX_PROCS),
		.MAX_RES   (MAX_RES),
		.UNIT_BITS (UNIT_BITS)
	) u_tables (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_alloc (UNIT_BITS'(allocated)),
		.wr_max   (UNIT_BITS'(maximum)),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_alloc (rd_alloc),
		.rd_max   (rd_max)
	);

	bsc_alu #(
		.ALU_W (ALU_W)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.c     (alu_c),
		.res   (alu_res),
		.flags (alu_flags)
	);

	bsc_seq #(
		.MAX_PROCS (MAX_PROCS),
		.MAX_RES   (MAX_RES),
		.UNIT_BITS (UNIT_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (check_start),
		.idle        (seq_idle),
		.n_procs     (n_procs),
		.n_res       (n_res),
		.totals      (total_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_alloc    (rd_alloc),
		.rd_max      (rd_max),
		.alu_op      (alu_op),
		.alu_a       (alu_a),
		.alu_b       (alu_b),
		.alu_c       (alu_c),
		.alu_res     (alu_res),
		.alu_flags   (alu_flags),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.entry_kind  (entry_kind),
		.process_out (process_out),
		.last        (last)
	);

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the banker's algorithm safety check unit
`timescale 1ns / 1ps

module testbench;
	import bsc_pkg::*;

	// cycles allowed after the last awaited entry before touching config or ending
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	localparam int RANDOM_BEATS  = 200;
	localparam int QUIET_BEATS   = 160;

	// one result beat as the block emits it
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] proc;
		logic       last;
	} sched_entry_t;

	// directed table rows
	typedef enum logic [1:0] {
		ROW_LOAD,
		ROW_CHECK,
		ROW_WRITE
	} row_op_t;

	typedef struct packed {
		row_op_t              op;
		logic [2:0]           p;
		logic [1:0]           c;
		logic [7:0]           a;
		logic [7:0]           mx;
		logic [CFG_IDX_W-1:0] idx;
		logic [7:0]           data;
		logic                 pinned;
		logic [3:0]           pin_orders;
		logic [1:0]           pin_kind;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  func;
	logic [2:0]            process_index;
	logic [1:0]            resource_index;
	logic [7:0]            allocated;
	logic [7:0]            maximum;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            entry_kind;
	logic [2:0]            process_out;
	logic                  last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	banker_safety_check_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.process_index  (process_index),
		.resource_index (resource_index),
		.allocated      (allocated),
		.maximum        (maximum),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.entry_kind     (entry_kind),
		.process_out    (process_out),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// shadow of the block: tables and configuration registers
	logic [7:0] held_alloc [BSC_MAX_PROCS][BSC_MAX_RES];
	logic [7:0] claim_max  [BSC_MAX_PROCS][BSC_MAX_RES];
	logic [7:0] unit_total [NUM_TOTALS];
	logic [3:0] proc_count;
	logic [2:0] res_count;

	// order entries and verdicts still owed by the block, oldest first
	sched_entry_t awaited[$];

	// typed expectation for the check beat currently on the bus
	logic       pin_on;
	logic [3:0] pin_orders;
	logic [1:0] pin_kind;

	logic idle_en;
	int   error_count;
	int   beats_sent;
	int   checks_sent;
	int   entries_seen;
	int   safe_seen;
	int   deadlock_seen;
	int   overalloc_seen;

	step_t steps[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#1_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic void push_entry(logic [1:0] kind, logic [2:0] proc, logic fin);
		sched_entry_t e;
		e.kind = kind;
		e.proc = proc;
		e.last = fin;
		awaited.push_back(e);
	endfunction

	// safety check over the shadow tables; queues every entry the run must produce
	function automatic void run_safety_check();
		int         n;
		int         m;
		int         sum;
		int         granted_cnt;
		logic [7:0] granted;
		logic [7:0] need;
		logic       progress;
		logic       fits;
		logic [10:0] avail [BSC_MAX_RES];
		n = (proc_count > BSC_MAX_PROCS) ? BSC_MAX_PROCS : proc_count;
		m = (res_count > BSC_MAX_RES) ? BSC_MAX_RES : res_count;
		granted = '0;
		granted_cnt = 0;
		// available per column, over-allocation ends the run at once
		for (int r = 0; r < m; r++) begin
			sum = 0;
			for (int i = 0; i < n; i++)
				sum += held_alloc[i][r];
			if (sum > unit_total[r]) begin
				push_entry(KIND_OVERALLOC, 3'd0, 1'b1);
				return;
			end
			avail[r] = 11'(unit_total[r] - sum);
		end
		// index-order passes until everyone is granted or a pass grants nobody
		while (granted_cnt < n) begin
			progress = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (!granted[i]) begin
					fits = 1'b1;
					for (int r = 0; r < m; r++) begin
						need = (claim_max[i][r] > held_alloc[i][r]) ?
							claim_max[i][r] - held_alloc[i][r] : 8'd0;
						if (need > avail[r])
							fits = 1'b0;
					end
					if (fits) begin
						for (int r = 0; r < m; r++)
							avail[r] = avail[r] + held_alloc[i][r];
						granted[i] = 1'b1;
						granted_cnt++;
						progress = 1'b1;
						push_entry(KIND_ORDER, 3'(i), 1'b0);
					end
				end
			end
			if (!progress) begin
				push_entry(KIND_DEADLOCK, 3'd0, 1'b1);
				return;
			end
		end
		push_entry(KIND_SAFE, 3'd0, 1'b1);
	endfunction

	// everything the block sees or emits is sampled here, on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			// config shadow
			if (cfg_we) begin
				case (cfg_index)
					CFG_TOTAL0: unit_total[0] <= cfg_data;
					CFG_TOTAL1: unit_total[1] <= cfg_data;
					CFG_TOTAL2: unit_total[2] <= cfg_data;
					CFG_TOTAL3: unit_total[3] <= cfg_data;
					CFG_PROCS:  proc_count <= cfg_data[3:0];
					CFG_RES:    res_count <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
			// accepted input beat: load the tables or queue the check outcome
			if (in_valid && in_ready) begin
				if (func == FUNC_LOAD) begin
					held_alloc[process_index][resource_index] = allocated;
					claim_max[process_index][resource_index] = maximum;
				end else if (pin_on) begin
					for (int i = 0; i < pin_orders; i++)
						push_entry(KIND_ORDER, 3'(i), 1'b0);
					push_entry(pin_kind, 3'd0, 1'b1);
				end else begin
					run_safety_check();
				end
			end
			// accepted result beat against the oldest expectation
			if (out_valid && out_ready) begin
				entries_seen++;
				if (awaited.size() == 0) begin
					$error("unexpected result: entry_kind %0d process_out %0d last %0d",
						entry_kind, process_out, last);
					error_count++;
				end else begin
					sched_entry_t e;
					e = awaited.pop_front();
					if (entry_kind !== e.kind) begin
						$error("entry_kind: expected %0d, got %0d", e.kind, entry_kind);
						error_count++;
					end
					if (process_out !== e.proc) begin
						$error("process_out: expected %0d, got %0d", e.proc, process_out);
						error_count++;
					end
					if (last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last);
						error_count++;
					end
				end
				case (entry_kind)
					KIND_SAFE:      safe_seen++;
					KIND_DEADLOCK:  deadlock_seen++;
					KIND_OVERALLOC: overalloc_seen++;
					default: begin
					end
				endcase
			end
		end
	end

	// result side back-pressure in random bursts
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_en && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// drive one input beat from a falling edge and hold it until taken
	task automatic send_beat(logic f, logic [2:0] p, logic [1:0] c, logic [7:0] a,
		logic [7:0] mx);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		process_index <= p;
		resource_index <= c;
		allocated <= a;
		maximum <= mx;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		beats_sent++;
		if (f == FUNC_CHECK)
			checks_sent++;
		@(negedge clk);
	endtask

	// drop valid, wait for every owed entry, then hold the bus quiet for SETTLE_CYCLES
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic step_t row_load(logic [2:0] p, logic [1:0] c, logic [7:0] a,
		logic [7:0] mx);
		step_t s;
		s = '0;
		s.op = ROW_LOAD;
		s.p = p;
		s.c = c;
		s.a = a;
		s.mx = mx;
		return s;
	endfunction

	function automatic step_t row_check(logic pinned, logic [3:0] orders, logic [1:0] kind);
		step_t s;
		s = '0;
		s.op = ROW_CHECK;
		s.a = 8'($urandom);
		s.mx = 8'($urandom);
		s.pinned = pinned;
		s.pin_orders = orders;
		s.pin_kind = kind;
		return s;
	endfunction

	function automatic step_t row_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
		step_t s;
		s = '0;
		s.op = ROW_WRITE;
		s.idx = idx;
		s.data = data;
		return s;
	endfunction

	// totals: mostly moderate, with empty and full pools now and then
	function automatic logic [7:0] pick_total();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 8'd0;
		if (sel == 1)
			return 8'd255;
		return 8'($urandom_range(4, 60));
	endfunction

	// allocation and claim for one entry, shaped so that column sums mostly fit
	task automatic load_entry(logic [2:0] p, logic [1:0] c);
		int unsigned sel;
		int          n_eff;
		int          cap;
		int          a;
		int          mx;
		n_eff = (proc_count == 0) ? 1 : ((proc_count > BSC_MAX_PROCS) ? BSC_MAX_PROCS : proc_count);
		sel = $urandom_range(0, 9);
		cap = unit_total[c] / n_eff;
		if (sel == 1)
			cap = cap + cap + 1;  // may tip the column into over-allocation
		a = $urandom_range(0, cap);
		if (a > 255)
			a = 255;
		if (sel == 2)
			mx = $urandom_range(0, a);  // claim below holding, need saturates
		else
			mx = a + $urandom_range(0, unit_total[c] / 2 + 1);
		if (mx > 255)
			mx = 255;
		if (sel == 0) begin
			// unconstrained noise
			a = $urandom_range(0, 255);
			mx = $urandom_range(0, 255);
		end
		send_beat(FUNC_LOAD, p, c, 8'(a), 8'(mx));
	endtask

	initial begin
		step_t s;
		int    rounds;
		int    n_in;
		int    m_in;
		logic [7:0] pdata;
		logic [7:0] rdata;

		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_LOAD;
		process_index = '0;
		resource_index = '0;
		allocated = '0;
		maximum = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pin_on = 1'b0;
		pin_orders = '0;
		pin_kind = KIND_ORDER;
		idle_en = 1'b1;
		error_count = 0;
		beats_sent = 0;
		checks_sent = 0;
		entries_seen = 0;
		safe_seen = 0;
		deadlock_seen = 0;
		overalloc_seen = 0;
		// shadow config starts at the reset values
		for (int r = 0; r < NUM_TOTALS; r++)
			unit_total[r] = TOTAL_RESET[r];
		proc_count = PROCS_RESET;
		res_count = RES_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every table entry gets written before any check reads it
		for (int i = 0; i < BSC_MAX_PROCS; i++)
			for (int r = 0; r < BSC_MAX_RES; r++)
				send_beat(FUNC_LOAD, 3'(i), 2'(r), 8'd0, 8'd0);

		// directed table, reset config is 10/5/7/0 with 5 processes and 3 resources
		steps.push_back(row_check(1'b1, 4'd5, KIND_SAFE));            // all idle, index order
		steps.push_back(row_load(3'd0, 2'd0, 8'd255, 8'd255));
		steps.push_back(row_check(1'b1, 4'd0, KIND_OVERALLOC));       // column above its total
		steps.push_back(row_load(3'd0, 2'd0, 8'd0, 8'd255));
		steps.push_back(row_check(1'b0, 4'd0, KIND_ORDER));           // p0 can never fit
		steps.push_back(row_write(CFG_TOTAL0, 8'd255));
		steps.push_back(row_check(1'b1, 4'd5, KIND_SAFE));            // need equals available
		steps.push_back(row_write(CFG_PROCS, 8'd0));
		steps.push_back(row_check(1'b1, 4'd0, KIND_SAFE));            // no processes
		steps.push_back(row_write(CFG_PROCS, 8'd15));                 // saturates at eight
		steps.push_back(row_write(CFG_RES, 8'd7));                    // saturates at four
		steps.push_back(row_load(3'd7, 2'd3, 8'd0, 8'd1));
		steps.push_back(row_check(1'b0, 4'd0, KIND_ORDER));           // partial order, deadlock
		steps.push_back(row_write(CFG_RES, 8'd0));
		steps.push_back(row_check(1'b1, 4'd8, KIND_SAFE));            // no resources, all fit
		steps.push_back(row_write(CFG_RES, 8'd4));
		steps.push_back(row_load(3'd3, 2'd1, 8'd255, 8'd0));
		steps.push_back(row_check(1'b1, 4'd0, KIND_OVERALLOC));
		steps.push_back(row_load(3'd3, 2'd1, 8'd5, 8'd0));            // claim below holding
		steps.push_back(row_check(1'b0, 4'd0, KIND_ORDER));
		steps.push_back(row_load(3'd7, 2'd3, 8'd0, 8'd0));
		steps.push_back(row_load(3'd0, 2'd2, 8'd0, 8'd7));
		steps.push_back(row_load(3'd5, 2'd2, 8'd7, 8'd7));
		steps.push_back(row_check(1'b0, 4'd0, KIND_ORDER));           // p0 only on second pass
		steps.push_back(row_write(CFG_TOTAL0, 8'd0));
		steps.push_back(row_check(1'b0, 4'd0, KIND_ORDER));

		foreach (steps[k]) begin
			s = steps[k];
			case (s.op)
				ROW_WRITE: begin
					settle();
					write_reg(s.idx, s.data);
				end
				ROW_LOAD: begin
					send_beat(FUNC_LOAD, s.p, s.c, s.a, s.mx);
				end
				default: begin
					pin_on = s.pinned;
					pin_orders = s.pin_orders;
					pin_kind = s.pin_kind;
					send_beat(FUNC_CHECK, s.p, s.c, s.a, s.mx);
				end
			endcase
		end
		pin_on = 1'b0;

		// random phases: fresh config, reload the active block, then load/check rounds
		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			settle();
			// quiet stretch at the end, elsewhere idling on most phases
			idle_en = (beats_sent < QUIET_BEATS) ? ($urandom_range(0, 3) != 0) : 1'b0;
			case ($urandom_range(0, 9))
				0:       pdata = 8'd0;
				1:       pdata = 8'($urandom_range(9, 15));
				default: pdata = 8'($urandom_range(1, 8));
			endcase
			if ($urandom_range(0, 7) == 0)
				pdata[7:4] = 4'($urandom_range(1, 15));  // bits above the field
			case ($urandom_range(0, 9))
				0:       rdata = 8'd0;
				1:       rdata = 8'($urandom_range(5, 7));
				default: rdata = 8'($urandom_range(1, 4));
			endcase
			write_reg(CFG_TOTAL0, pick_total());
			write_reg(CFG_TOTAL1, pick_total());
			write_reg(CFG_TOTAL2, pick_total());
			write_reg(CFG_TOTAL3, pick_total());
			write_reg(CFG_PROCS, pdata);
			write_reg(CFG_RES, rdata);
			@(negedge clk);

			n_in = (proc_count > BSC_MAX_PROCS) ? BSC_MAX_PROCS : proc_count;
			m_in = (res_count > BSC_MAX_RES) ? BSC_MAX_RES : res_count;
			for (int i = 0; i < n_in; i++)
				for (int r = 0; r < m_in; r++)
					load_entry(3'(i), 2'(r));

			rounds = $urandom_range(2, 5);
			for (int k = 0; k < rounds; k++) begin
				repeat ($urandom_range(0, 5))
					load_entry(3'($urandom_range(0, BSC_MAX_PROCS - 1)),
						2'($urandom_range(0, BSC_MAX_RES - 1)));
				send_beat(FUNC_CHECK, 3'($urandom), 2'($urandom), 8'($urandom),
					8'($urandom));
			end
		end

		// drain everything still owed, then watch for stray beats
		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d check runs, %0d result beats checked", checks_sent, entries_seen);
		$display("summary: verdicts %0d safe, %0d deadlock, %0d over-allocated, %0d errors",
			safe_seen, deadlock_seen, overalloc_seen, error_count);
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_table_mem.sv
rtl/bsc_alu.sv
rtl/bsc_seq.sv
rtl/banker_safety_check_unit.sv
dv/testbench.sv
